FILE: rtl/lrrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect retry controller package
// Shared types and register codes for the retry controller and its helpers.
// ----------------------------------------------------------------------------
package lrrc_pkg;

  localparam int unsigned NOW_W      = 32;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STATION_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_DHCP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CREDENTIALS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_WAIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIES_WAIT    = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [COUNT_W-1:0] ATTEMPT_WAIT_RST   = 8'd1;
  localparam logic [COUNT_W-1:0] ATTEMPT_LIMIT_RST  = 8'd30;
  localparam logic [15:0]        SERIES_WAIT_RST    = 16'd60;

  typedef struct packed {
    logic               station_mode;
    logic               use_dhcp;
    logic               credentials_set;
    logic [COUNT_W-1:0] attempt_limit;
  } lrrc_mode_t;

  typedef struct packed {
    logic               sleep_flag;
    logic [NOW_W-1:0]   sleep_start;
    logic               attempt_running;
    logic [NOW_W-1:0]   attempt_start;
    logic [COUNT_W-1:0] failed_attempts;
    logic               blink_running;
    logic [NOW_W-1:0]   blink_start;
    logic               was_down;
  } lrrc_state_t;

  typedef struct packed {
    logic               link_up;
    logic               connected_event;
    logic               start_connect;
    logic               disconnect_request;
    logic               reboot_to_setup;
    logic               led_toggle;
    logic               led_off;
    logic               sleeping;
    logic [COUNT_W-1:0] attempt_count;
  } lrrc_result_t;

endpackage

FILE: rtl/lrrc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Poll channel
// Valid/ready channel carrying one poll: time stamp and link status flags.
// ----------------------------------------------------------------------------
interface lrrc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        address_assigned;
  logic        station_associated;

  modport source (output valid, output now_ms, output address_assigned,
                  output station_associated, input ready);
  modport sink (input valid, input now_ms, input address_assigned,
                input station_associated, output ready);
endinterface

FILE: rtl/lrrc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the requests and status of one poll.
// ----------------------------------------------------------------------------
interface lrrc_out_if;
  logic       valid;
  logic       ready;
  logic       link_up;
  logic       connected_event;
  logic       start_connect;
  logic       disconnect_request;
  logic       reboot_to_setup;
  logic       led_toggle;
  logic       led_off;
  logic       sleeping;
  logic [7:0] attempt_count;

  modport source (output valid, output link_up, output connected_event,
                  output start_connect, output disconnect_request,
                  output reboot_to_setup, output led_toggle, output led_off,
                  output sleeping, output attempt_count, input ready);
  modport sink (input valid, input link_up, input connected_event,
                input start_connect, input disconnect_request,
                input reboot_to_setup, input led_toggle, input led_off,
                input sleeping, input attempt_count, output ready);
endinterface

FILE: rtl/lrrc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Retry controller poll step
// Next state and result of one poll, from the current state and the poll.
// ----------------------------------------------------------------------------
module lrrc_step #(
  parameter int unsigned BLINK_PERIOD_MS = 500,
  parameter int unsigned ALIM_W          = 18,
  parameter int unsigned SLIM_W          = 26
) (
  input  lrrc_pkg::lrrc_mode_t   mode_i,
  input  logic [ALIM_W-1:0]      attempt_lim_i,
  input  logic [SLIM_W-1:0]      series_lim_i,
  input  logic [31:0]            now_ms_i,
  input  logic                   address_assigned_i,
  input  logic                   station_associated_i,
  input  lrrc_pkg::lrrc_state_t  state_i,
  output lrrc_pkg::lrrc_state_t  state_o,
  output lrrc_pkg::lrrc_result_t result_o
);
  import lrrc_pkg::*;

  logic             up;
  logic [NOW_W-1:0] sleep_elapsed;
  logic [NOW_W-1:0] blink_elapsed;
  logic [NOW_W-1:0] attempt_elapsed;

  assign up = mode_i.use_dhcp ? address_assigned_i : station_associated_i;

  always_comb begin
    lrrc_state_t  st;
    lrrc_result_t res;
    st  = state_i;
    res = '0;
    sleep_elapsed   = now_ms_i - state_i.sleep_start;
    blink_elapsed   = '0;
    attempt_elapsed = '0;
    if (mode_i.station_mode) begin
      if (!up) begin
        st.was_down = 1'b1;
        if (state_i.sleep_flag) begin
          if (64'(sleep_elapsed) >= 64'(series_lim_i)) begin
            st.sleep_flag = 1'b0;
          end
        end else begin
          if (!st.attempt_running) begin
            st.attempt_running = 1'b1;
            st.attempt_start   = now_ms_i;
            if (st.failed_attempts == '0) begin
              res.start_connect   = mode_i.credentials_set;
              res.reboot_to_setup = !mode_i.credentials_set;
            end
          end
          if (!st.blink_running) begin
            st.blink_running = 1'b1;
            st.blink_start   = now_ms_i;
          end
          blink_elapsed   = now_ms_i - st.blink_start;
          attempt_elapsed = now_ms_i - st.attempt_start;
          if (64'(blink_elapsed) > 64'(BLINK_PERIOD_MS)) begin
            res.led_toggle   = 1'b1;
            st.blink_running = 1'b0;
          end
          if (64'(attempt_elapsed) > 64'(attempt_lim_i)) begin
            st.failed_attempts = st.failed_attempts + COUNT_W'(1);
            st.attempt_running = 1'b0;
          end
          // A finished series drops the link and starts the sleep period.
          if (st.failed_attempts == mode_i.attempt_limit) begin
            st.sleep_flag          = 1'b1;
            st.sleep_start         = now_ms_i;
            st.attempt_running     = 1'b0;
            st.blink_running       = 1'b0;
            st.failed_attempts     = '0;
            res.disconnect_request = 1'b1;
            res.led_off            = 1'b1;
          end
        end
      end else begin
        if (st.was_down) begin
          res.connected_event = 1'b1;
          st.was_down         = 1'b0;
        end
        if (st.failed_attempts != '0) begin
          st.failed_attempts = '0;
          st.attempt_running = 1'b0;
          st.blink_running   = 1'b0;
          res.led_off        = 1'b1;
        end
      end
    end
    res.link_up       = up;
    res.sleeping      = st.sleep_flag;
    res.attempt_count = st.failed_attempts;
    state_o  = st;
    result_o = res;
  end

endmodule

FILE: rtl/link_reconnect_retry_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect retry controller
// Watches the link on every poll; in station mode drives connection attempts,
// LED blinking, failure counting, disconnect-and-sleep and the connected event.
// ----------------------------------------------------------------------------
//  Channel   Dir  Beat content
//  in_ch     in   now_ms, address_assigned, station_associated
//  out_ch    out  link_up, pulses, sleeping, attempt_count
//  cfg       in   cfg_we_i, cfg_index_i, cfg_data_i (write only)
//
//  A poll beat is registered, evaluated against the state and lands in the
//  output register; while the output is taken, one poll per cycle is sustained.
//  The state registers update when a poll moves into the output register. Reset
//  sets was_down, clears the rest of the state and the valid flags and loads
//  the register defaults. A stalled output holds one result and one more poll
//  in the input register; ready drops only when both are full.
// ----------------------------------------------------------------------------
module link_reconnect_retry_controller #(
  parameter int unsigned BLINK_PERIOD_MS  = 500,
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lrrc_in_if.sink                           in_ch,
  lrrc_out_if.source                        out_ch,
  input  logic                              cfg_we_i,
  input  logic [lrrc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lrrc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import lrrc_pkg::*;

  localparam int unsigned TICK_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned ALIM_W = COUNT_W + TICK_W;
  localparam int unsigned SLIM_W = 16 + TICK_W;
  localparam logic [ALIM_W-1:0] ALIM_RST =
    ALIM_W'(ATTEMPT_WAIT_RST) * ALIM_W'(TICKS_PER_SECOND);
  localparam logic [SLIM_W-1:0] SLIM_RST =
    SLIM_W'(SERIES_WAIT_RST) * SLIM_W'(TICKS_PER_SECOND);
  // The link is taken as down at start.
  localparam lrrc_state_t STATE_RST = '{was_down: 1'b1, default: '0};

  // Configuration; wait times are kept as tick limits.
  lrrc_mode_t        mode_q;
  logic [ALIM_W-1:0] attempt_lim_q;
  logic [SLIM_W-1:0] series_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q.station_mode    <= 1'b0;
      mode_q.use_dhcp        <= 1'b1;
      mode_q.credentials_set <= 1'b0;
      mode_q.attempt_limit   <= ATTEMPT_LIMIT_RST;
      attempt_lim_q          <= ALIM_RST;
      series_lim_q           <= SLIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STATION_MODE:  mode_q.station_mode    <= cfg_data_i[0];
        CFG_USE_DHCP:      mode_q.use_dhcp        <= cfg_data_i[0];
        CFG_CREDENTIALS:   mode_q.credentials_set <= cfg_data_i[0];
        CFG_ATTEMPT_WAIT:  attempt_lim_q <=
          ALIM_W'(cfg_data_i[COUNT_W-1:0]) * ALIM_W'(TICKS_PER_SECOND);
        CFG_ATTEMPT_LIMIT: mode_q.attempt_limit   <= cfg_data_i[COUNT_W-1:0];
        CFG_SERIES_WAIT:   series_lim_q <=
          SLIM_W'(cfg_data_i) * SLIM_W'(TICKS_PER_SECOND);
        default: ;
      endcase
    end
  end

  // Input register.
  logic             s1_valid_q;
  logic [NOW_W-1:0] s1_now_q;
  logic             s1_addr_q;
  logic             s1_assoc_q;
  logic             out_valid_q;
  lrrc_result_t     out_q;
  logic             out_free;
  logic             s1_move;
  logic             in_take;

  assign out_free     = !out_valid_q || out_ch.ready;
  assign s1_move      = s1_valid_q && out_free;
  assign in_ch.ready  = !s1_valid_q || out_free;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_now_q   <= in_ch.now_ms;
      s1_addr_q  <= in_ch.address_assigned;
      s1_assoc_q <= in_ch.station_associated;
    end
  end

  // Controller state.
  lrrc_state_t  state_q;
  lrrc_state_t  state_d;
  lrrc_result_t result_d;

  lrrc_step #(
    .BLINK_PERIOD_MS (BLINK_PERIOD_MS),
    .ALIM_W          (ALIM_W),
    .SLIM_W          (SLIM_W)
  ) u_step (
    .mode_i               (mode_q),
    .attempt_lim_i        (attempt_lim_q),
    .series_lim_i         (series_lim_q),
    .now_ms_i             (s1_now_q),
    .address_assigned_i   (s1_addr_q),
    .station_associated_i (s1_assoc_q),
    .state_i              (state_q),
    .state_o              (state_d),
    .result_o             (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RST;
    end else if (s1_move) begin
      state_q <= state_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= result_d;
    end
  end

  assign out_ch.valid              = out_valid_q;
  assign out_ch.link_up            = out_q.link_up;
  assign out_ch.connected_event    = out_q.connected_event;
  assign out_ch.start_connect      = out_q.start_connect;
  assign out_ch.disconnect_request = out_q.disconnect_request;
  assign out_ch.reboot_to_setup    = out_q.reboot_to_setup;
  assign out_ch.led_toggle         = out_q.led_toggle;
  assign out_ch.led_off            = out_q.led_off;
  assign out_ch.sleeping           = out_q.sleeping;
  assign out_ch.attempt_count      = out_q.attempt_count;

endmodule

FILE: rtl/lrrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Retry controller checker
// Port-level properties of the retry controller, bound to the top level.
// ----------------------------------------------------------------------------
module lrrc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       link_up_i,
  input logic       connected_event_i,
  input logic       start_connect_i,
  input logic       disconnect_request_i,
  input logic       reboot_to_setup_i,
  input logic       led_off_i,
  input logic       sleeping_i,
  input logic [7:0] attempt_count_i
);

  // A held result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // A connection start and a setup reboot come from the same start decision.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(start_connect_i && reboot_to_setup_i))
    else $error("connect and reboot requested together");

  // Entering sleep clears the series and switches the LED off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && disconnect_request_i |->
      sleeping_i && led_off_i && attempt_count_i == 8'd0)
    else $error("disconnect without sleep entry");

  // The connected event and attempt requests follow the link flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!connected_event_i || link_up_i) &&
                    (!(start_connect_i || reboot_to_setup_i) || !link_up_i))
    else $error("event or attempt inconsistent with link state");

endmodule

bind link_reconnect_retry_controller lrrc_checker u_lrrc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_ch.valid),
  .out_ready_i          (out_ch.ready),
  .link_up_i            (out_ch.link_up),
  .connected_event_i    (out_ch.connected_event),
  .start_connect_i      (out_ch.start_connect),
  .disconnect_request_i (out_ch.disconnect_request),
  .reboot_to_setup_i    (out_ch.reboot_to_setup),
  .led_off_i            (out_ch.led_off),
  .sleeping_i           (out_ch.sleeping),
  .attempt_count_i      (out_ch.attempt_count)
);
